// ----- hw/rtl/ber_tlv_integer_decoder_macros.svh -----
// Assertion macros shared by the BER TLV integer decoder RTL.
// Each macro expands to one labeled concurrent assertion on clk_i / rst_ni.
`ifndef BER_TLV_INTEGER_DECODER_MACROS_SVH
`define BER_TLV_INTEGER_DECODER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BER_TLV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BER_TLV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ber_tlv_pkg.sv -----
// Shared types and constants of the BER TLV integer decoder.
// No dependencies; used by ber_tlv_cfg, ber_tlv_core and the top level.
package ber_tlv_pkg;

  localparam int unsigned CfgDataW = 8;
  localparam int unsigned CfgIdxW  = 1;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegExpectedTag = 1'd0;
  localparam logic [CfgIdxW-1:0] RegMaxWidth    = 1'd1;

  localparam logic [7:0] TagInteger      = 8'h02;
  localparam logic [2:0] MaxWidthDefault = 3'd4;

  // Longest content that passes the width check is 7 + 1 bytes
  localparam int unsigned ValCntW = 4;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StTag   = 2'd1,
    StForm  = 2'd2,
    StTooBig = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] expected_tag;
    logic [2:0] max_width;
  } cfg_t;

  typedef struct packed {
    logic [31:0] value;
    logic [15:0] value_length;
    status_e     status;
  } res_t;

endpackage

// ----- hw/rtl/ber_tlv_cfg.sv -----
// Configuration registers of the BER TLV integer decoder.
// Depends on ber_tlv_pkg for the register indexes and cfg_t.
module ber_tlv_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ber_tlv_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ber_tlv_pkg::CfgDataW-1:0]  cfg_data_i,
  output ber_tlv_pkg::cfg_t                 cfg_o
);
  import ber_tlv_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegExpectedTag: cfg_d.expected_tag = cfg_data_i;
        RegMaxWidth:    cfg_d.max_width    = cfg_data_i[2:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_tag <= TagInteger;
      cfg_q.max_width    <= MaxWidthDefault;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/ber_tlv_core.sv -----
// Per-byte decode of one BER TLV element: tag, length forms, value accumulation.
// Depends on ber_tlv_pkg; the result is combinational and registered by the top level.
module ber_tlv_core #(
  parameter int unsigned MAX_LENGTH_BYTES = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        data_byte_i,
  input  logic              start_req_i,
  input  ber_tlv_pkg::cfg_t cfg_i,
  output logic              res_valid_o,
  output ber_tlv_pkg::res_t res_o
);
  import ber_tlv_pkg::*;

  localparam int unsigned LenCntW = $clog2(MAX_LENGTH_BYTES + 1);
  localparam logic [6:0] MaxLenBytes = 7'(MAX_LENGTH_BYTES);

  localparam logic [1:0] PhIdle    = 2'd0;
  localparam logic [1:0] PhLen     = 2'd1;
  localparam logic [1:0] PhLongLen = 2'd2;
  localparam logic [1:0] PhValue   = 2'd3;

  logic [1:0]         phase_q, phase_d;
  logic [LenCntW-1:0] len_left_q, len_left_d;
  logic [15:0]        clen_q, clen_d;
  logic [ValCntW-1:0] val_left_q, val_left_d;
  logic [31:0]        acc_q, acc_d;
  logic               sign_q, sign_d;

  logic        len_done;
  logic [15:0] len_val;
  logic [15:0] len_limit;
  logic [15:0] long_len;
  logic [31:0] acc_next;
  logic        sign_next;

  assign len_limit = 16'(cfg_i.max_width) + 16'd1;
  assign long_len  = (clen_q > 16'h00FF) ? 16'hFFFF : {clen_q[7:0], data_byte_i};
  assign acc_next  = {acc_q[23:0], data_byte_i};
  assign sign_next = (val_left_q == clen_q[ValCntW-1:0]) ? data_byte_i[7] : sign_q;

  always_comb begin
    phase_d     = phase_q;
    len_left_d  = len_left_q;
    clen_d      = clen_q;
    val_left_d  = val_left_q;
    acc_d       = acc_q;
    sign_d      = sign_q;
    len_done    = 1'b0;
    len_val     = '0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (step_i) begin
      if (start_req_i) begin
        // A start always aborts whatever element was in flight
        if (data_byte_i != cfg_i.expected_tag) begin
          res_valid_o   = 1'b1;
          res_o.status  = StTag;
          phase_d       = PhIdle;
        end else begin
          phase_d = PhLen;
        end
      end else begin
        case (phase_q)
          PhLen: begin
            if (data_byte_i[7]) begin
              if (data_byte_i[6:0] == 7'd0 || data_byte_i[6:0] > MaxLenBytes) begin
                res_valid_o  = 1'b1;
                res_o.status = StForm;
                phase_d      = PhIdle;
              end else begin
                len_left_d = LenCntW'(data_byte_i[6:0]);
                clen_d     = '0;
                phase_d    = PhLongLen;
              end
            end else begin
              len_done = 1'b1;
              len_val  = {8'd0, data_byte_i};
            end
          end
          PhLongLen: begin
            clen_d     = long_len;
            len_left_d = len_left_q - LenCntW'(1);
            if (len_left_q == LenCntW'(1)) begin
              len_done = 1'b1;
              len_val  = long_len;
            end
          end
          PhValue: begin
            sign_d     = sign_next;
            acc_d      = acc_next;
            val_left_d = val_left_q - ValCntW'(1);
            if (val_left_q == ValCntW'(1)) begin
              res_valid_o        = 1'b1;
              res_o.status       = StOk;
              res_o.value_length = clen_q;
              res_o.value        = acc_next;
              // Sign extend short INTEGER content; four bytes or more stays as is
              if (cfg_i.expected_tag == TagInteger && sign_next && clen_q < 16'd4) begin
                res_o.value = acc_next | (32'hFFFF_FFFF << {clen_q[1:0], 3'b000});
              end
              phase_d = PhIdle;
            end
          end
          default: phase_d = phase_q;
        endcase

        if (len_done) begin
          clen_d = len_val;
          if (len_val > len_limit) begin
            res_valid_o        = 1'b1;
            res_o.status       = StTooBig;
            res_o.value_length = len_val;
            phase_d            = PhIdle;
          end else if (len_val == 16'd0) begin
            res_valid_o  = 1'b1;
            res_o.status = StOk;
            phase_d      = PhIdle;
          end else begin
            val_left_d = len_val[ValCntW-1:0];
            acc_d      = '0;
            sign_d     = 1'b0;
            phase_d    = PhValue;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      len_left_q <= '0;
      clen_q     <= '0;
      val_left_q <= '0;
      acc_q      <= '0;
      sign_q     <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      len_left_q <= len_left_d;
      clen_q     <= clen_d;
      val_left_q <= val_left_d;
      acc_q      <= acc_d;
      sign_q     <= sign_d;
    end
  end

endmodule

// ----- hw/rtl/ber_tlv_integer_decoder.sv -----
// BER TLV integer decoder: one byte per transaction in, one result per element out.
// Block usage:
//   Input channel (in_valid_i/in_ready_o) carries data_byte_i and start_req_i.
//   A transaction with start_req_i set is the tag of a new element; it drops
//   any element still being decoded. Bytes arriving while idle are ignored.
//   Output channel (out_valid_o/out_ready_i) carries value_o, value_length_o
//   and status_o: one transaction per completed element or per error.
//   Data path: a byte is captured in the input register at its accepting edge,
//   decoded against the element state once the result register can take its
//   output, and any result it completes is written to the result register at
//   the end of that cycle, from where out_valid_o offers it.
//   Throughput: one byte per cycle while no result waits on out_ready_i; the
//   registered state update in ber_tlv_core is the only recurrence.
//   Stall: while a result waits for out_ready_i, a held byte stays in the
//   input register and in_ready_o stays low; an empty one may still take a byte.
//   Reset: element state idle, expected tag 0x02, max width 4 (content up to 5 bytes).
//   Configuration writes (cfg_we_i) take effect at the next edge and must be
//   issued only while the block is idle.
// Depends on ber_tlv_pkg, ber_tlv_cfg, ber_tlv_core and the assertion macros.
`include "ber_tlv_integer_decoder_macros.svh"

module ber_tlv_integer_decoder #(
  parameter int unsigned MAX_LENGTH_BYTES = 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       data_byte_i,
  input  logic                             start_req_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [31:0]                      value_o,
  output logic [15:0]                      value_length_o,
  output logic [1:0]                       status_o,
  input  logic                             cfg_we_i,
  input  logic [ber_tlv_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ber_tlv_pkg::CfgDataW-1:0] cfg_data_i
);
  import ber_tlv_pkg::*;

  cfg_t       cfg;
  logic       in_valid_q;
  logic [7:0] data_q;
  logic       start_q;
  logic       advance;
  logic       step;
  logic       res_valid;
  res_t       res;
  logic       out_valid_q;
  res_t       res_q;

  ber_tlv_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Decode stage moves only when the result register can take its output
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q  <= data_byte_i;
      start_q <= start_req_i;
    end
  end

  ber_tlv_core #(
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (data_q),
    .start_req_i (start_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign value_o        = res_q.value;
  assign value_length_o = res_q.value_length;
  assign status_o       = res_q.status;

  `BER_TLV_ASSERT_NOW(a_err_value_zero, out_valid_o && status_o != StOk, value_o == 32'd0,
    "error result carries a nonzero value")
  `BER_TLV_ASSERT_NOW(a_form_len_zero,
    out_valid_o && (status_o == StTag || status_o == StForm), value_length_o == 16'd0,
    "tag or form error carries a nonzero length")
  `BER_TLV_ASSERT_NOW(a_ok_len_bound, out_valid_o && status_o == StOk,
    value_length_o <= 16'(cfg.max_width) + 16'd1, "accepted element exceeds width limit")
  `BER_TLV_ASSERT_NEXT(a_held_byte_kept, in_valid_q && !advance, in_valid_q,
    "stalled byte dropped from input register")

endmodule
